### src/assert_macros.svh
// Assertion shorthands for the RTL files; pfvb_fifo is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/pfvb_pkg.sv
`default_nettype none

package pfvb_pkg;

    localparam int PLANE_LIMIT_DEF     = 64;
    localparam int VERTS_PER_PLANE_DEF = 32;
    localparam int VERTEX_STORE_DEF    = 2112;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_HEADER = 2'd1;
    localparam logic [1:0] OP_VERTEX = 2'd2;

    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd0;
    localparam logic [1:0] CFG_FLOOR_MARGIN = 2'd1;
    localparam logic [1:0] CFG_MIN_HALF     = 2'd2;

    localparam logic [2:0] RSN_LABEL      = 3'd0;
    localparam logic [2:0] RSN_BELOW_GRID = 3'd1;
    localparam logic [2:0] RSN_TOO_SMALL  = 3'd2;
    localparam logic [2:0] RSN_STORE_FULL = 3'd3;
    localparam logic [2:0] RSN_LIMIT      = 3'd4;

    localparam logic [7:0] LABEL_FLOOR   = 8'd2;
    localparam logic [7:0] LABEL_CEILING = 8'd3;

    localparam logic [30:0] FLOOR_MARGIN_RST = 31'd3277;
    localparam logic [30:0] MIN_HALF_RST     = 31'd4915;

    typedef enum logic [1:0] {
        CMD_REJECT,
        CMD_PLANE,
        CMD_VERTEX
    } cmd_op_t;

    typedef struct packed {
        logic [5:0]  batch;
        logic [4:0]  vidx;
        logic        last;
        logic [11:0] start;
        logic [4:0]  tris;
        logic [10:0] total;
    } meta_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [2:0]         reason;
        logic               rect;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] qw;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        meta_t              meta;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [2:0]         reason;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        meta_t              meta;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -38'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/pfvb_front.sv
`default_nettype none

module pfvb_front
    import pfvb_pkg::*;
#(
    parameter int PLANE_LIMIT     = PLANE_LIMIT_DEF,
    parameter int VERTS_PER_PLANE = VERTS_PER_PLANE_DEF,
    parameter int VERTEX_STORE    = VERTEX_STORE_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         accept,
    input  wire logic [1:0]   operation,
    input  wire logic [303:0] payload,
    output cmd_t              cmd,
    output logic              push
);

    localparam int PSW = $clog2(PLANE_LIMIT + 1);
    localparam int BCW = $clog2(PLANE_LIMIT + 1);
    localparam int SOW = $clog2(VERTEX_STORE + 1);
    localparam int CW  = $clog2(VERTS_PER_PLANE + 2);

    logic signed [31:0] grid_height_reg;
    logic [30:0]        floor_margin_reg;
    logic [30:0]        min_half_reg;

    logic [CW-1:0]  expected_reg;
    logic [CW-1:0]  vcount_reg;
    logic           plane_acc_reg;
    logic [BCW-1:0] batch_reg;
    logic [PSW-1:0] seen_reg;
    logic [SOW-1:0] offset_reg;
    logic [10:0]    total_reg;
    logic           full_reg;

    logic signed [31:0] coord_a, coord_b, coord_c, half_x, half_y;
    logic [7:0]         label;
    logic signed [7:0]  vertex_count;
    logic signed [33:0] floor_level;
    logic               below, too_small, no_room, rect;
    logic [CW-1:0]      emitted, tris;
    logic [11:0]        total_sum;
    logic [10:0]        total_next;
    int                 cnt_int;

    assign coord_a      = payload[31:0];
    assign coord_b      = payload[63:32];
    assign coord_c      = payload[95:64];
    assign half_x       = payload[255:224];
    assign half_y       = payload[287:256];
    assign label        = payload[295:288];
    assign vertex_count = payload[303:296];

    always_comb
    begin
        floor_level = 34'(grid_height_reg) + $signed({3'b000, floor_margin_reg});
        below     = 34'(coord_b) < floor_level;
        too_small = ($signed({half_x[31], half_x}) < $signed({2'b00, min_half_reg}))
                 || ($signed({half_y[31], half_y}) < $signed({2'b00, min_half_reg}));
        no_room = (32'(offset_reg) + 32'(VERTS_PER_PLANE) + 32'd1) > 32'(VERTEX_STORE);
        cnt_int = int'(vertex_count);
        if (cnt_int < 0)
        begin
            cnt_int = 0;
        end
        if (cnt_int > VERTS_PER_PLANE)
        begin
            cnt_int = VERTS_PER_PLANE;
        end
        rect       = cnt_int < 3;
        emitted    = rect ? CW'(4) : CW'(cnt_int);
        tris       = emitted - CW'(2);
        total_sum  = {1'b0, total_reg} + 12'(tris);
        total_next = total_sum[11] ? 11'h7ff : total_sum[10:0];
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = CMD_REJECT;
        push     = 1'b0;
        if (accept && operation == OP_HEADER)
        begin
            push = 1'b1;
            priority if (seen_reg >= PSW'(PLANE_LIMIT))
            begin
                cmd.reason = RSN_LIMIT;
            end
            else if (full_reg)
            begin
                cmd.reason = RSN_STORE_FULL;
            end
            else if (label == LABEL_FLOOR || label == LABEL_CEILING)
            begin
                cmd.reason = RSN_LABEL;
            end
            else if (below)
            begin
                cmd.reason = RSN_BELOW_GRID;
            end
            else if (too_small)
            begin
                cmd.reason = RSN_TOO_SMALL;
            end
            else if (no_room)
            begin
                cmd.reason = RSN_STORE_FULL;
            end
            else
            begin
                cmd.op         = CMD_PLANE;
                cmd.rect       = rect;
                cmd.a          = coord_a;
                cmd.b          = coord_b;
                cmd.c          = coord_c;
                cmd.qx         = payload[127:96];
                cmd.qy         = payload[159:128];
                cmd.qz         = payload[191:160];
                cmd.qw         = payload[223:192];
                cmd.hx         = half_x;
                cmd.hy         = half_y;
                cmd.meta.batch = 6'(batch_reg);
                cmd.meta.start = 12'(offset_reg);
                cmd.meta.tris  = 5'(tris);
                cmd.meta.total = total_next;
            end
        end
        else if (accept && operation == OP_VERTEX && plane_acc_reg
                 && vcount_reg < expected_reg)
        begin
            push           = 1'b1;
            cmd.op         = CMD_VERTEX;
            cmd.a          = coord_a;
            cmd.b          = coord_b;
            cmd.meta.batch = 6'(batch_reg - BCW'(1));
            cmd.meta.vidx  = 5'(vcount_reg);
            cmd.meta.last  = (vcount_reg + CW'(1)) == expected_reg;
            cmd.meta.start = 12'(offset_reg - SOW'(expected_reg));
            cmd.meta.tris  = 5'(expected_reg - CW'(2));
            cmd.meta.total = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg  <= '0;
            floor_margin_reg <= FLOOR_MARGIN_RST;
            min_half_reg     <= MIN_HALF_RST;
            expected_reg     <= '0;
            vcount_reg       <= '0;
            plane_acc_reg    <= 1'b0;
            batch_reg        <= '0;
            seen_reg         <= '0;
            offset_reg       <= '0;
            total_reg        <= '0;
            full_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                    CFG_FLOOR_MARGIN: floor_margin_reg <= cfg_data[30:0];
                    CFG_MIN_HALF:     min_half_reg     <= cfg_data[30:0];
                    default:          ;
                endcase
            end
            if (accept && operation == OP_FRAME)
            begin
                expected_reg  <= '0;
                vcount_reg    <= '0;
                plane_acc_reg <= 1'b0;
                batch_reg     <= '0;
                seen_reg      <= '0;
                offset_reg    <= '0;
                total_reg     <= '0;
                full_reg      <= 1'b0;
            end
            else if (accept && operation == OP_HEADER)
            begin
                if (seen_reg < PSW'(PLANE_LIMIT))
                begin
                    seen_reg <= seen_reg + PSW'(1);
                end
                plane_acc_reg <= 1'b0;
                expected_reg  <= '0;
                vcount_reg    <= '0;
                if (cmd.op == CMD_PLANE)
                begin
                    batch_reg     <= batch_reg + BCW'(1);
                    offset_reg    <= offset_reg + SOW'(emitted);
                    total_reg     <= total_next;
                    plane_acc_reg <= !rect;
                    expected_reg  <= rect ? '0 : emitted;
                end
                else if (seen_reg < PSW'(PLANE_LIMIT) && !full_reg
                         && label != LABEL_FLOOR && label != LABEL_CEILING
                         && !below && !too_small && no_room)
                begin
                    full_reg <= 1'b1;
                end
            end
            else if (push && cmd.op == CMD_VERTEX)
            begin
                vcount_reg <= vcount_reg + CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/pfvb_fifo.sv
`default_nettype none

module pfvb_fifo
    import pfvb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_data,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [NW-1:0] count_reg;

    assign head  = mem_reg[rd_reg];
    assign empty = count_reg == '0;
    assign full  = count_reg == NW'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_overflow, push |-> !full, "queue written while full")
    `ASSERT_CLK(a_no_underflow, pop |-> !empty, "queue read while empty")
    `ASSERT_CLK(a_count_up, (push && !pop) |=> count_reg == $past(count_reg) + NW'(1), "queue count lost a write")

endmodule

`default_nettype wire

### src/pfvb_back.sv
`default_nettype none

module pfvb_back
    import pfvb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      head,
    input  wire logic empty,
    output logic      pop,
    output result_t   result,
    output logic      result_valid,
    input  wire logic result_ready
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_BMUL,
        B_BACC,
        B_AXES,
        B_PMUL,
        B_PACC,
        B_EMIT
    } bstate_t;

    bstate_t            state_reg;
    cmd_t               cmd_reg;
    logic [3:0]         step_reg;
    logic [1:0]         corner_reg;
    logic signed [64:0] prod_reg;
    logic signed [35:0] term_reg [9];
    logic signed [31:0] axu_reg [3];
    logic signed [31:0] axv_reg [3];
    logic signed [31:0] cen_reg [3];
    logic signed [35:0] wacc_reg [3];
    result_t            out_reg;
    logic               out_valid_reg;

    logic signed [31:0] ma;
    logic signed [32:0] mb;
    logic signed [32:0] lx, ly;
    logic signed [37:0] one;
    logic               out_free;
    logic               emit;

    assign pop          = (state_reg == B_IDLE) && !empty;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign emit         = (state_reg == B_EMIT) && out_free;
    assign one          = 38'sd1073741824;

    always_comb
    begin
        if (cmd_reg.op == CMD_VERTEX)
        begin
            lx = 33'(cmd_reg.a);
            ly = 33'(cmd_reg.b);
        end
        else
        begin
            // Corners run (-,-), (+,-), (+,+), (-,+); half extents are never negative here.
            lx = (corner_reg[0] == corner_reg[1]) ? -33'(cmd_reg.hx) : 33'(cmd_reg.hx);
            ly = corner_reg[1] ? 33'(cmd_reg.hy) : -33'(cmd_reg.hy);
        end
        ma = '0;
        mb = '0;
        if (state_reg == B_BMUL)
        begin
            unique case (step_reg)
                4'd0:    begin ma = cmd_reg.qx; mb = 33'(cmd_reg.qx); end
                4'd1:    begin ma = cmd_reg.qx; mb = 33'(cmd_reg.qy); end
                4'd2:    begin ma = cmd_reg.qx; mb = 33'(cmd_reg.qz); end
                4'd3:    begin ma = cmd_reg.qy; mb = 33'(cmd_reg.qy); end
                4'd4:    begin ma = cmd_reg.qy; mb = 33'(cmd_reg.qz); end
                4'd5:    begin ma = cmd_reg.qz; mb = 33'(cmd_reg.qz); end
                4'd6:    begin ma = cmd_reg.qw; mb = 33'(cmd_reg.qx); end
                4'd7:    begin ma = cmd_reg.qw; mb = 33'(cmd_reg.qy); end
                4'd8:    begin ma = cmd_reg.qw; mb = 33'(cmd_reg.qz); end
                default: begin ma = '0; mb = '0; end
            endcase
        end
        else
        begin
            ma = step_reg[0] ? axv_reg[step_reg[2:1]] : axu_reg[step_reg[2:1]];
            mb = step_reg[0] ? ly : lx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            corner_reg    <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        cmd_reg    <= head;
                        step_reg   <= '0;
                        corner_reg <= '0;
                        unique case (head.op)
                            CMD_PLANE:
                            begin
                                cen_reg[0] <= head.a;
                                cen_reg[1] <= head.b;
                                cen_reg[2] <= head.c;
                                state_reg  <= B_BMUL;
                            end
                            CMD_VERTEX:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    wacc_reg[i] <= 36'(cen_reg[i]);
                                end
                                state_reg <= B_PMUL;
                            end
                            default:
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    wacc_reg[i] <= '0;
                                end
                                state_reg <= B_EMIT;
                            end
                        endcase
                    end
                end
                B_BMUL:
                begin
                    prod_reg  <= ma * mb;
                    state_reg <= B_BACC;
                end
                B_BACC:
                begin
                    term_reg[step_reg] <= 36'((prod_reg + (65'sd1 <<< 28)) >>> 29);
                    if (step_reg == 4'd8)
                    begin
                        state_reg <= B_AXES;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= B_BMUL;
                    end
                end
                B_AXES:
                begin
                    // Terms: xx xy xz yy yz zz wx wy wz.
                    axu_reg[0] <= sat32(one - (38'(term_reg[3]) + 38'(term_reg[5])));
                    axu_reg[1] <= sat32(38'(term_reg[1]) + 38'(term_reg[8]));
                    axu_reg[2] <= sat32(38'(term_reg[2]) - 38'(term_reg[7]));
                    axv_reg[0] <= sat32(38'(term_reg[1]) - 38'(term_reg[8]));
                    axv_reg[1] <= sat32(one - (38'(term_reg[0]) + 38'(term_reg[5])));
                    axv_reg[2] <= sat32(38'(term_reg[4]) + 38'(term_reg[6]));
                    step_reg   <= '0;
                    if (cmd_reg.rect)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            wacc_reg[i] <= 36'(cen_reg[i]);
                        end
                        state_reg <= B_PMUL;
                    end
                    else
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_PMUL:
                begin
                    prod_reg  <= ma * mb;
                    state_reg <= B_PACC;
                end
                B_PACC:
                begin
                    wacc_reg[step_reg[2:1]] <= wacc_reg[step_reg[2:1]]
                        + 36'((prod_reg + (65'sd1 <<< 29)) >>> 30);
                    if (step_reg == 4'd5)
                    begin
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= B_PMUL;
                    end
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg.kind       <= cmd_reg.op == CMD_REJECT;
                        out_reg.reason     <= cmd_reg.reason;
                        out_reg.wx         <= sat32(38'(wacc_reg[0]));
                        out_reg.wy         <= sat32(38'(wacc_reg[1]));
                        out_reg.wz         <= sat32(38'(wacc_reg[2]));
                        out_reg.meta.batch <= cmd_reg.meta.batch;
                        out_reg.meta.start <= cmd_reg.meta.start;
                        out_reg.meta.tris  <= cmd_reg.meta.tris;
                        out_reg.meta.total <= cmd_reg.meta.total;
                        out_reg.meta.vidx  <= (cmd_reg.op == CMD_PLANE) ? 5'(corner_reg)
                                                                       : cmd_reg.meta.vidx;
                        out_reg.meta.last  <= (cmd_reg.op == CMD_PLANE) ? (corner_reg == 2'd3)
                                                                       : cmd_reg.meta.last;
                        if (cmd_reg.op == CMD_PLANE && corner_reg != 2'd3)
                        begin
                            corner_reg <= corner_reg + 2'd1;
                            step_reg   <= '0;
                            for (int i = 0; i < 3; i++)
                            begin
                                wacc_reg[i] <= 36'(cen_reg[i]);
                            end
                            state_reg <= B_PMUL;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/plane_fan_vertex_builder.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser operation, tdata header or vertex fields
// m_*       out  m_tvalid/m_tready  tuser kind, tlast last, tdata result fields
// cfg_*     in   cfg_we             cfg_index register, cfg_data value
//
// A rejected header goes straight to the back end's output register; stray vertices
// and unused items never reach it. Every accepted header first builds the plane axes,
// a rectangle header then its four corners, and each polygon vertex its position, all
// on one shared 32x33 multiplier. A result waits in the output register while m_tready is low.
// The input stalls only while the two-entry command queue is full.
// Reset clears all counters and the queue; registers return to their defaults.
`default_nettype none

module plane_fan_vertex_builder
    import pfvb_pkg::*;
#(
    parameter int PLANE_LIMIT     = PLANE_LIMIT_DEF,
    parameter int VERTS_PER_PLANE = VERTS_PER_PLANE_DEF,
    parameter int VERTEX_STORE    = VERTEX_STORE_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // coord_a, coord_b, coord_c, quat_x, quat_y, quat_z, quat_w, half_x, half_y,
    // label, vertex_count
    input  wire logic [303:0] s_tdata,
    // operation
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // reject_reason, world_x, world_y, world_z, batch_index, vertex_index,
    // vertex_start, triangle_count, total_triangles, zero fill
    output logic [143:0]      m_tdata,
    // kind
    output logic              m_tuser,
    output logic              m_tlast
);

    cmd_t    push_cmd, head;
    logic    push, pop, empty, full;
    result_t res;

    assign s_tready = !full;

    pfvb_front #(
        .PLANE_LIMIT     (PLANE_LIMIT),
        .VERTS_PER_PLANE (VERTS_PER_PLANE),
        .VERTEX_STORE    (VERTEX_STORE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (s_tvalid && s_tready),
        .operation (s_tuser),
        .payload   (s_tdata),
        .cmd       (push_cmd),
        .push      (push)
    );

    pfvb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    pfvb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result       (res),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.meta.last;
    assign m_tdata = {6'b0, res.meta.total, res.meta.tris, res.meta.start, res.meta.vidx,
                      res.meta.batch, res.wz, res.wy, res.wx, res.reason};

endmodule

`default_nettype wire
